>>> sv/assert_macros.svh
// Assertion helpers shared by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> sv/ped_pkg.sv
package ped_pkg;

	// Escape parser phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PCT  = 2'd1,
		PH_HIGH = 2'd2,
		PH_DROP = 2'd3
	} phase_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_BYTE   = 3'd0,
		ST_TRUNC  = 3'd1,
		ST_BADHEX = 3'd2,
		ST_NUL    = 3'd3,
		ST_END    = 3'd4
	} status_t;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	// Hex digit decode: bit 4 set when the byte is a hex digit, low nibble is its value
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] v;
		begin
			v = 8'd0;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				v = c - CH_ZERO;
				hex_digit = {1'b1, v[3:0]};
			end else if (c >= CH_UA && c <= CH_UF) begin
				v = c - CH_UA + HEX_TEN;
				hex_digit = {1'b1, v[3:0]};
			end else if (c >= CH_LA && c <= CH_LF) begin
				v = c - CH_LA + HEX_TEN;
				hex_digit = {1'b1, v[3:0]};
			end else begin
				hex_digit = {1'b0, v[3:0]};
			end
		end
	endfunction

endpackage

>>> sv/percent_escape_decoder_core.sv
// Path: input register, then result register, which drives the master side.
// One word per cycle unless the master side stalls; one decode step between the registers.
// Escape bytes that produce no result still move through while the master side stalls.
// Reset (arst_n low, asynchronous): both stages empty, parser idle, stored nibble zero.
module percent_escape_decoder_core import ped_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // in_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [2:0] m_axis_tuser,   // [2:0] status
	output logic       m_axis_tlast    // out_last
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result stage
	logic       valid_s2;
	logic [7:0] byte_s2;
	status_t    status_s2;
	logic       last_s2;

	// parser state
	phase_t     phase_q, phase_d;
	logic [3:0] nib_q, nib_d;

	// decode of the word in the input stage
	logic [4:0] hex;
	logic       emit;
	logic [7:0] res_byte;
	status_t    res_status;
	logic       res_last;

	logic       out_free;
	logic       adv_s1;
	logic       acc_in;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && (out_free || !emit);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign acc_in        = s_axis_tvalid && s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// parser state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			nib_q   <= 4'd0;
		end else if (adv_s1) begin
			phase_q <= phase_d;
			nib_q   <= nib_d;
		end
	end

	// next state and result for the word in the input stage
	always_comb begin
		hex        = hex_digit(byte_s1);
		phase_d    = phase_q;
		nib_d      = nib_q;
		emit       = 1'b0;
		res_byte   = 8'd0;
		res_status = ST_BYTE;
		res_last   = last_s1;
		unique case (phase_q)
			PH_IDLE: begin
				if (byte_s1 == CH_PCT) begin
					if (last_s1) begin
						emit       = 1'b1;
						res_status = ST_TRUNC;
					end else begin
						phase_d = PH_PCT;
					end
				end else begin
					emit     = 1'b1;
					res_byte = byte_s1;
				end
			end
			PH_PCT: begin
				if (last_s1) begin
					emit       = 1'b1;
					res_status = ST_TRUNC;
					phase_d    = PH_IDLE;
				end else if (!hex[4]) begin
					emit       = 1'b1;
					res_status = ST_BADHEX;
					phase_d    = PH_DROP;
				end else begin
					nib_d   = hex[3:0];
					phase_d = PH_HIGH;
				end
			end
			PH_HIGH: begin
				emit = 1'b1;
				if (!hex[4]) begin
					res_status = ST_BADHEX;
					phase_d    = last_s1 ? PH_IDLE : PH_DROP;
				end else if (nib_q == 4'd0 && hex[3:0] == 4'd0) begin
					res_status = ST_NUL;
					phase_d    = last_s1 ? PH_IDLE : PH_DROP;
				end else begin
					res_byte = {nib_q, hex[3:0]};
					phase_d  = PH_IDLE;
				end
			end
			PH_DROP: begin
				// swallow the rest of the string, end marker on its last byte
				if (last_s1) begin
					emit       = 1'b1;
					res_status = ST_END;
					phase_d    = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && emit) begin
			byte_s2   <= res_byte;
			status_s2 <= res_status;
			last_s2   <= res_last;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = byte_s2;
	assign m_axis_tuser  = status_s2;
	assign m_axis_tlast  = last_s2;

endmodule

>>> sv/ped_checker.sv
`include "assert_macros.svh"

module ped_checker import ped_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input logic       s_axis_tlast,   // in_last
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,   // [7:0] out_byte
	input logic [2:0] m_axis_tuser,   // [2:0] status
	input logic       m_axis_tlast    // out_last
);

	logic m_stall;
	logic err_word;
	logic end_word;

	assign m_stall  = m_axis_tvalid && !m_axis_tready;
	assign err_word = m_axis_tvalid && (m_axis_tuser != ST_BYTE);
	assign end_word = m_axis_tvalid && (m_axis_tuser == ST_TRUNC || m_axis_tuser == ST_END);

	// status code stays within the defined set
	`ASSERT_IMPLY(a_status_range, clk, arst_n, m_axis_tvalid, m_axis_tuser <= ST_END)
	// error words carry a zero data byte
	`ASSERT_IMPLY(a_err_zero, clk, arst_n, err_word, m_axis_tdata == 8'd0)
	// truncation and end markers always close the string
	`ASSERT_IMPLY(a_end_last, clk, arst_n, end_word, m_axis_tlast)
	// a stalled result word holds
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, m_stall,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind percent_escape_decoder_core ped_checker u_ped_checker (.*);

>>> sim/tb.sv
module tb;
	import ped_pkg::*;

	// One decoded word as it should leave the master side
	typedef struct packed {
		logic [7:0] data;
		status_t    status;
		logic       last;
	} decoded_word_t;

	// Tracks the escape parser and holds the decoded words still owed by the block
	class escape_decode_board;
		phase_t        parse_phase;
		logic [3:0]    first_nibble;
		decoded_word_t owed_words[$];
		int            mismatches;

		function new();
			parse_phase  = PH_IDLE;
			first_nibble = 4'd0;
			mismatches   = 0;
		endfunction

		// Bit 4 set for a hex digit, low nibble holds its value
		function logic [4:0] digit_value(input logic [7:0] c);
			logic [7:0] v;
			logic       ok;
			v  = 8'd0;
			ok = 1'b1;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				v = c - CH_ZERO;
			end else if (c >= CH_UA && c <= CH_UF) begin
				v = c - CH_UA + HEX_TEN;
			end else if (c >= CH_LA && c <= CH_LF) begin
				v = c - CH_LA + HEX_TEN;
			end else begin
				ok = 1'b0;
			end
			return {ok, v[3:0]};
		endfunction

		function void owe(input logic [7:0] b, input status_t st, input logic l);
			decoded_word_t w;
			w.data   = b;
			w.status = st;
			w.last   = l;
			owed_words.push_back(w);
		endfunction

		// Escape error: drop the rest of the string unless this word ends it
		function void flag_error(input status_t st, input logic l);
			parse_phase = l ? PH_IDLE : PH_DROP;
			owe(8'h00, st, l);
		endfunction

		// Advance the parser by one accepted input word
		function void note_input(input logic [7:0] b, input logic l);
			logic [4:0] dig;
			dig = digit_value(b);
			case (parse_phase)
				PH_IDLE: begin
					if (b == CH_PCT) begin
						if (l)
							flag_error(ST_TRUNC, 1'b1);
						else
							parse_phase = PH_PCT;
					end else begin
						owe(b, ST_BYTE, l);
					end
				end
				PH_PCT: begin
					if (l) begin
						flag_error(ST_TRUNC, 1'b1);
					end else if (!dig[4]) begin
						flag_error(ST_BADHEX, 1'b0);
					end else begin
						first_nibble = dig[3:0];
						parse_phase  = PH_HIGH;
					end
				end
				PH_HIGH: begin
					if (!dig[4]) begin
						flag_error(ST_BADHEX, l);
					end else if (first_nibble == 4'd0 && dig[3:0] == 4'd0) begin
						flag_error(ST_NUL, l);
					end else begin
						parse_phase = PH_IDLE;
						owe({first_nibble, dig[3:0]}, ST_BYTE, l);
					end
				end
				default: begin
					if (l) begin
						parse_phase = PH_IDLE;
						owe(8'h00, ST_END, 1'b1);
					end
				end
			endcase
		endfunction

		task report_mismatch(input string what, input int got, input int want);
			$display("MISMATCH %s: got %0h, expected %0h", what, got, want);
			mismatches++;
		endtask

		// Compare one accepted output word with the oldest owed word
		task check_result(input logic [7:0] b, input logic [2:0] st, input logic l);
			decoded_word_t w;
			if (owed_words.size() == 0) begin
				report_mismatch("word with nothing owed", b, 0);
			end else begin
				w = owed_words.pop_front();
				if (b !== w.data)
					report_mismatch("out_byte", b, w.data);
				if (st !== w.status)
					report_mismatch("status", st, w.status);
				if (l !== w.last)
					report_mismatch("out_last", l, w.last);
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic       m_axis_tlast;

	escape_decode_board board;
	logic [7:0] url_text[$];
	int         src_idle_pct = 12;
	int         sink_idle_pct = 79;
	int         words_sent = 0;

	percent_escape_decoder_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Output side: check accepted words, stall at random
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Input side: optional idle gap, then hold the word until it is taken
	task automatic push_word(input logic [7:0] b, input logic l);
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= l;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.note_input(b, l);
		words_sent++;
	endtask

	// Send url_text as one string, tlast on its final byte
	task automatic send_text();
		int k;
		for (k = 0; k < url_text.size(); k++)
			push_word(url_text[k], k == url_text.size() - 1);
	endtask

	task automatic send_ascii(input string s);
		int k;
		url_text.delete();
		for (k = 0; k < s.len(); k++)
			url_text.push_back(s[k]);
		send_text();
	endtask

	// Hold the input side off until every owed word has come back
	task automatic drain_pause();
		s_axis_tvalid <= 1'b0;
		while (board.owed_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
		if (nib < 4'd10)
			return CH_ZERO + nib;
		return (upper ? CH_UA : CH_LA) + nib - HEX_TEN;
	endfunction

	function logic [3:0] rand_nibble();
		// lean toward zero so that escaped NULs show up
		return ($urandom_range(7) == 0) ? 4'd0 : 4'($urandom_range(15));
	endfunction

	// Mostly well-formed strings with random content, some broken escapes
	function void build_random_text();
		int n;
		int k;
		int pick;
		url_text.delete();
		n = $urandom_range(12, 1);
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				url_text.push_back(8'($urandom_range(255)));
			end else if (pick < 82) begin
				url_text.push_back(CH_PCT);
				url_text.push_back(hex_char(rand_nibble(), 1'($urandom_range(1))));
				url_text.push_back(hex_char(rand_nibble(), 1'($urandom_range(1))));
			end else if (pick < 85) begin
				url_text.push_back(CH_PCT);
				url_text.push_back(CH_ZERO);
				url_text.push_back(CH_ZERO);
			end else if (pick < 91) begin
				url_text.push_back(CH_PCT);
				url_text.push_back(8'($urandom_range(255)));
				url_text.push_back(8'($urandom_range(255)));
			end else if (pick < 96) begin
				url_text.push_back(CH_PCT);
				url_text.push_back(hex_char(rand_nibble(), 1'($urandom_range(1))));
				url_text.push_back(8'($urandom_range(255)));
			end else begin
				url_text.push_back(CH_PCT);
			end
		end
	endfunction

	initial begin
		int pass_no;
		int target;
		int guard;
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings: byte extremes, both hex cases, each escape error
		url_text.delete();
		url_text.push_back(8'h00);
		url_text.push_back(8'hFF);
		send_text();
		send_ascii("%aF%0A");
		send_ascii("%");
		send_ascii("%4");
		send_ascii("%Z");
		send_ascii("%Gy");
		send_ascii("%4G");
		send_ascii("%00");
		send_ascii("%00q");

		// Random strings under three idle patterns
		for (pass_no = 0; pass_no < 3; pass_no++) begin
			case (pass_no)
				0: begin
					src_idle_pct  = 12;
					sink_idle_pct = 79;
				end
				1: begin
					src_idle_pct  = 79;
					sink_idle_pct = 12;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			target = words_sent + 375;
			while (words_sent < target) begin
				build_random_text();
				send_text();
			end
			drain_pause();
		end

		// Wait out anything still in flight, then look for stray words
		for (guard = 0; guard < 20000 && board.owed_words.size() != 0; guard++)
			@(posedge clk);
		if (board.owed_words.size() != 0)
			board.report_mismatch("words never delivered", 0, board.owed_words.size());
		repeat (16) @(posedge clk);
		if (board.mismatches == 0)
			$display("percent_escape_decoder_core verification clean");
		else
			$display("percent_escape_decoder_core verification failed");
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#3000000;
		$display("percent_escape_decoder_core verification failed");
		$finish;
	end

endmodule
